/* src/kpls_pkg.sv */
// shared constants, types and codes for the key press / long press scanner
// no dependencies
`default_nettype none

package kpls_pkg;

	localparam int KEY_COUNT  = 5;
	localparam int LEVEL_BITS = 5;
	localparam int CODE_W     = 4;
	localparam int COUNT_W    = 8;
	localparam int HOLD_W     = 4;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// request opcodes
	localparam logic [OP_W-1:0] OP_SCAN  = 2'd0;
	localparam logic [OP_W-1:0] OP_GET   = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LONG    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd2;

	localparam logic [COUNT_W-1:0] LONG_RESET    = 8'd25;
	localparam logic [COUNT_W-1:0] REPEAT_RESET  = 8'd50;
	localparam logic [HOLD_W-1:0]  RELEASE_RESET = 4'd4;

	localparam logic [CODE_W-1:0] CODE_NONE = '0;

	typedef struct packed {
		logic [COUNT_W-1:0] long_ticks;
		logic [COUNT_W-1:0] repeat_ticks;
		logic [HOLD_W-1:0]  release_ticks;
	} cfg_t;

	typedef struct packed {
		logic short_hit;
		logic long_hit;
	} post_t;

	typedef struct packed {
		logic              hit;
		logic [CODE_W-1:0] code;
	} merge_t;

endpackage

`default_nettype wire

/* src/kpls_ifs.sv */
// valid/ready channel interfaces: scan request, key code response, config write
// depends on kpls_pkg
`default_nettype none

interface kpls_req_if;
	import kpls_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       opcode;
	logic [LEVEL_BITS-1:0] key_levels;
	modport source (output valid, opcode, key_levels, input ready);
	modport sink (input valid, opcode, key_levels, output ready);
endinterface

interface kpls_rsp_if;
	import kpls_pkg::*;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] key_code;
	modport source (output valid, key_code, input ready);
	modport sink (input valid, key_code, output ready);
endinterface

interface kpls_cfg_if;
	import kpls_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/key_press_long_press_scanner.sv */
// top level: config registers, key lanes, merge, key buffer and response register
// depends on kpls_pkg, kpls_ifs, kpls_lane, kpls_merge
//
// channel | dir  | accepted when          | payload
// req     | sink | req.valid & req.ready  | opcode, key_levels
// rsp     | src  | rsp.valid & rsp.ready  | key_code
// cfg     | sink | cfg.valid (ready high) | index, data
//
// one request per cycle while req.ready is high; its response appears in the
// response register the cycle after the transfer.
// all key lanes update in parallel in the cycle of a scan transfer.
// req.ready drops only while a response is held and rsp.ready is low.
// reset clears the lanes and the buffer and loads the default thresholds.
`default_nettype none

module key_press_long_press_scanner
	import kpls_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	kpls_req_if.sink  req,
	kpls_rsp_if.source rsp,
	kpls_cfg_if.sink  cfg
);

	cfg_t              cfg_q;
	logic [CODE_W-1:0] buffer_q;
	logic              rsp_valid_q;
	logic [CODE_W-1:0] rsp_code_q;
	logic              req_xfer, scan_en;
	logic [KEY_COUNT-1:0] pressed;
	post_t             posts [KEY_COUNT];
	merge_t            merged;

	assign cfg.ready = 1'b1;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_xfer  = req.valid && req.ready;
	assign scan_en   = req_xfer && (req.opcode == OP_SCAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_ticks    <= LONG_RESET;
			cfg_q.repeat_ticks  <= REPEAT_RESET;
			cfg_q.release_ticks <= RELEASE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LONG:    cfg_q.long_ticks    <= cfg.data;
				REG_REPEAT:  cfg_q.repeat_ticks  <= cfg.data;
				REG_RELEASE: cfg_q.release_ticks <= cfg.data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	// keys without a level bit read as released
	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
		if (k < LEVEL_BITS) begin : g_lvl
			assign pressed[k] = !req.key_levels[k];
		end else begin : g_none
			assign pressed[k] = 1'b0;
		end
		kpls_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (scan_en),
			.pressed (pressed[k]),
			.cfg     (cfg_q),
			.post    (posts[k])
		);
	end

	kpls_merge u_merge (
		.posts  (posts),
		.merged (merged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_q    <= CODE_NONE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_xfer) begin
				unique case (req.opcode)
					OP_SCAN:  if (merged.hit) buffer_q <= merged.code;
					OP_GET:   buffer_q <= CODE_NONE;
					OP_FLUSH: buffer_q <= CODE_NONE;
					default: ;
				endcase
			end
			if (req_xfer) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			rsp_code_q <= (req.opcode == OP_GET) ? buffer_q : CODE_NONE;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.key_code = rsp_code_q;

endmodule

`default_nettype wire

/* src/kpls_lane.sv */
// per-key lane: press counter, release hold-off and long flag
// depends on kpls_pkg
`default_nettype none

module kpls_lane
	import kpls_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic pressed,
	input  wire cfg_t cfg,
	output post_t     post
);

	logic [COUNT_W-1:0] count_q, count_d, base_count, inc;
	logic [HOLD_W-1:0]  hold_q, hold_d;
	logic               long_q, long_d;

	always_comb begin
		count_d    = count_q;
		hold_d     = hold_q;
		long_d     = long_q;
		post       = '0;
		base_count = count_q;
		inc        = '0;
		if (pressed) begin
			// a fresh press starts from a cleared count and flag
			if (hold_q == '0) begin
				base_count = '0;
				long_d     = 1'b0;
			end
			hold_d = cfg.release_ticks;
			inc    = base_count + COUNT_W'(1);
			if (inc == cfg.long_ticks) begin
				post.long_hit = 1'b1;
				long_d        = 1'b1;
			end
			count_d = (inc >= cfg.repeat_ticks) ? '0 : inc;
		end else if (hold_q != '0) begin
			hold_d = hold_q - HOLD_W'(1);
			post.short_hit = (hold_q == HOLD_W'(1)) && !long_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hold_q  <= '0;
			long_q  <= 1'b0;
		end else if (en) begin
			count_q <= count_d;
			hold_q  <= hold_d;
			long_q  <= long_d;
		end
	end

endmodule

`default_nettype wire

/* src/kpls_merge.sv */
// merges lane posts into one key code, highest key index wins
// depends on kpls_pkg
`default_nettype none

module kpls_merge
	import kpls_pkg::*;
(
	input  wire post_t posts [KEY_COUNT],
	output merge_t     merged
);

	always_comb begin
		merged = '0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			if (posts[k].long_hit) begin
				merged.hit  = 1'b1;
				merged.code = CODE_W'(1 + KEY_COUNT + k);
			end else if (posts[k].short_hit) begin
				merged.hit  = 1'b1;
				merged.code = CODE_W'(1 + k);
			end
		end
	end

endmodule

`default_nettype wire

/* src/kpls_chk.sv */
// port-level checks for the key scanner, bound to the top level
// depends on kpls_pkg
`default_nettype none

module kpls_chk
	import kpls_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire logic [OP_W-1:0]   req_opcode,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire logic [CODE_W-1:0] rsp_key_code
);

	logic req_xfer;
	assign req_xfer = req_valid && req_ready;

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_code))
		else $error("response dropped or changed while stalled");

	// every request gives a response next cycle; only a get carries a code
	a_rsp_next: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> rsp_valid &&
			($past(req_opcode) == OP_GET || rsp_key_code == CODE_NONE))
		else $error("missing response or code on a non-get request");

	// codes stay within the short and long ranges
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_key_code <= CODE_W'(2 * KEY_COUNT))
		else $error("key code out of range");

	// a get straight after a flush finds the buffer empty
	a_flush_get: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && req_opcode == OP_FLUSH) ##1 (req_xfer && req_opcode == OP_GET)
			|=> rsp_key_code == CODE_NONE)
		else $error("get after flush returned a code");

endmodule

bind key_press_long_press_scanner kpls_chk u_kpls_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_opcode   (req.opcode),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_key_code (rsp.key_code)
);

`default_nettype wire

/* tb/tb.sv */
// testbench for the key press / long press scanner: directed and random scan, get and
// flush traffic, checked against an in-bench model of the key lanes and the key buffer
// depends on kpls_pkg, kpls_ifs and key_press_long_press_scanner
`default_nettype none

module tb;
	import kpls_pkg::*;

	localparam logic [OP_W-1:0]       OP_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0]  REG_UNUSED  = 2'd3;
	localparam logic [LEVEL_BITS-1:0] ALL_UP      = '1;
	localparam int                    QUIET_LIMIT = 2000;
	localparam int                    LONG_HOLD   = 40;

	logic clk = 1'b0;
	logic arst_n;

	kpls_req_if req_ch ();
	kpls_rsp_if rsp_ch ();
	kpls_cfg_if cfg_ch ();

	key_press_long_press_scanner DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// mirror of the key lanes, buffer and thresholds
	logic [COUNT_W-1:0] lane_press [KEY_COUNT];
	logic [HOLD_W-1:0]  lane_holdoff [KEY_COUNT];
	logic               lane_long [KEY_COUNT];
	logic [CODE_W-1:0]  held_code;
	logic [COUNT_W-1:0] thr_long;
	logic [COUNT_W-1:0] thr_repeat;
	logic [HOLD_W-1:0]  thr_release;

	logic [CODE_W-1:0] pending_codes [$];
	int errors        = 0;
	int quiet         = 0;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int hold_left     = 0;
	int items_sent    = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// advances the mirror by one request and returns the code it reports
	function automatic logic [CODE_W-1:0] scanner_next(input logic [OP_W-1:0] op,
			input logic [LEVEL_BITS-1:0] levels);
		logic [CODE_W-1:0] code;
		logic pressed;
		code = CODE_NONE;
		case (op)
			OP_SCAN: begin
				for (int k = 0; k < KEY_COUNT; k++) begin
					pressed = (k < LEVEL_BITS) ? !levels[k] : 1'b0;
					if (pressed) begin
						if (lane_holdoff[k] == '0) begin
							lane_long[k]  = 1'b0;
							lane_press[k] = '0;
						end
						lane_holdoff[k] = thr_release;
						lane_press[k]   = lane_press[k] + 1'b1;
						if (lane_press[k] == thr_long) begin
							held_code    = CODE_W'(1 + KEY_COUNT + k);
							lane_long[k] = 1'b1;
						end
						if (lane_press[k] >= thr_repeat)
							lane_press[k] = '0;
					end else if (lane_holdoff[k] != '0) begin
						lane_holdoff[k] = lane_holdoff[k] - 1'b1;
						if (lane_holdoff[k] == '0 && !lane_long[k])
							held_code = CODE_W'(1 + k);
					end
				end
			end
			OP_GET: begin
				code      = held_code;
				held_code = CODE_NONE;
			end
			OP_FLUSH: held_code = CODE_NONE;
			default: ;
		endcase
		return code;
	endfunction

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	always @(posedge clk) begin
		logic [CODE_W-1:0] want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_codes.size() == 0) begin
				$error("key_code expected none actual %0d", rsp_ch.key_code);
				errors++;
			end else begin
				want = pending_codes.pop_front();
				if (rsp_ch.key_code !== want) begin
					$error("key_code expected %0d actual %0d", want, rsp_ch.key_code);
					errors++;
				end
			end
		end
	end

	// ends the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("key_press_long_press_scanner: mismatch");
			$finish;
		end
	end

	task automatic send_req(input logic [OP_W-1:0] op, input logic [LEVEL_BITS-1:0] levels);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.key_levels <= levels;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		pending_codes.push_back(scanner_next(op, levels));
		items_sent++;
	endtask

	// lower valid and wait for every outstanding code, plus the response latency
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_codes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_LONG:    thr_long    = value;
			REG_REPEAT:  thr_repeat  = value;
			REG_RELEASE: thr_release = value[HOLD_W-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// a scan tick, now and then followed by a get, a flush or an unused opcode
	task automatic scan_tick(input logic [LEVEL_BITS-1:0] levels);
		int roll;
		send_req(OP_SCAN, levels);
		roll = $urandom_range(99);
		if (roll < 15)
			send_req(OP_GET, LEVEL_BITS'($urandom));
		else if (roll < 18)
			send_req(OP_FLUSH, LEVEL_BITS'($urandom));
		else if (roll < 20)
			send_req(OP_UNUSED, LEVEL_BITS'($urandom));
	endtask

	// press / hold / release sequences with random content, some pure noise
	task automatic run_episodes(input int n_items, input int hold_max);
		int first;
		int style;
		logic [LEVEL_BITS-1:0] held;
		first = items_sent;
		while (items_sent - first < n_items) begin
			style = $urandom_range(9);
			held  = (style < 7) ? LEVEL_BITS'(1) << $urandom_range(LEVEL_BITS - 1)
			                    : LEVEL_BITS'($urandom);
			repeat ($urandom_range(1, hold_max))
				scan_tick((style == 9) ? LEVEL_BITS'($urandom) : ~held);
			// let the hold-off run out, sometimes cut short by a stray press
			repeat ($urandom_range(0, 17))
				scan_tick(($urandom_range(9) == 0) ? LEVEL_BITS'($urandom) : ALL_UP);
			send_req(OP_GET, LEVEL_BITS'($urandom));
		end
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] long_val,
			input logic [CFG_DATA_W-1:0] repeat_val, input logic [CFG_DATA_W-1:0] release_val,
			input int idle_pct, input int stall_pct, input int n_items, input int hold_max);
		drain();
		cfg_write(REG_LONG, long_val);
		cfg_write(REG_REPEAT, repeat_val);
		cfg_write(REG_RELEASE, release_val);
		send_idle_pct = idle_pct;
		rsp_stall_pct <= stall_pct;
		run_episodes(n_items, hold_max);
	endtask

	// reset thresholds: empty buffer, unused opcode, short presses, flush, ties
	task automatic test_directed();
		send_req(OP_GET, ALL_UP);
		send_req(OP_UNUSED, '0);
		send_req(OP_FLUSH, '0);
		repeat (2) send_req(OP_SCAN, 5'h1E);
		repeat (4) send_req(OP_SCAN, ALL_UP);
		send_req(OP_GET, '0);
		send_req(OP_GET, ALL_UP);
		send_req(OP_SCAN, 5'h0F);
		repeat (4) send_req(OP_SCAN, ALL_UP);
		send_req(OP_FLUSH, ALL_UP);
		send_req(OP_GET, '0);
		// every key released in the same tick: highest index wins
		send_req(OP_SCAN, '0);
		repeat (4) send_req(OP_SCAN, ALL_UP);
		send_req(OP_GET, '0);
	endtask

	task automatic test_random_phases();
		run_phase(LONG_RESET, REPEAT_RESET, CFG_DATA_W'(RELEASE_RESET), 0, 0, 20, 40);
		run_phase(8'd3, 8'd8, 8'd2, 61, 0, 8, 12);
		run_phase(8'd1, 8'd2, 8'd1, 0, 61, 8, 6);
		// long threshold zero, wrap every tick, release masked down to zero
		run_phase(8'd0, 8'd1, 8'hF0, 18, 18, 8, 8);
		run_phase(8'd9, 8'd6, 8'd3, 0, 0, 8, 12);
		run_phase(8'd5, 8'd200, 8'd15, 18, 18, 8, 10);
		run_phase(8'd2, 8'd0, 8'd5, 61, 0, 8, 6);
	endtask

	task automatic test_mid_press_lowering();
		run_phase(8'd20, 8'd30, 8'd3, 18, 18, 0, 1);
		repeat (10) send_req(OP_SCAN, 5'h1D);
		send_req(OP_GET, ALL_UP);
		drain();
		// key 1 still held: the counter is now past the lowered wrap point
		cfg_write(REG_REPEAT, 8'd4);
		repeat (3) send_req(OP_SCAN, 5'h1D);
		repeat (3) send_req(OP_SCAN, ALL_UP);
		send_req(OP_GET, ALL_UP);
	endtask

	task automatic test_long_extreme();
		run_phase(8'd255, 8'd255, 8'hFF, 18, 18, 0, 1);
		for (int t = 0; t < 257; t++) begin
			send_req(OP_SCAN, 5'h17);
			if (t % 64 == 63 || t == 255)
				send_req(OP_GET, LEVEL_BITS'($urandom));
		end
		repeat (16) send_req(OP_SCAN, ALL_UP);
		send_req(OP_GET, ALL_UP);
	endtask

	task automatic test_backpressure();
		drain();
		send_idle_pct = 0;
		rsp_stall_pct <= 0;
		hold_left     <= LONG_HOLD;
		run_episodes(6, 6);
		drain();
		run_episodes(6, 6);
	endtask

	task automatic test_unused_register();
		drain();
		cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
		send_idle_pct = 0;
		rsp_stall_pct <= 61;
		run_episodes(8, 8);
	endtask

	initial begin
		req_ch.valid      = 1'b0;
		req_ch.opcode     = OP_SCAN;
		req_ch.key_levels = ALL_UP;
		rsp_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_LONG;
		cfg_ch.data       = '0;
		arst_n            = 1'b0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			lane_press[k]   = '0;
			lane_holdoff[k] = '0;
			lane_long[k]    = 1'b0;
		end
		held_code   = CODE_NONE;
		thr_long    = LONG_RESET;
		thr_repeat  = REPEAT_RESET;
		thr_release = RELEASE_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phases();
		test_mid_press_lowering();
		test_long_extreme();
		test_backpressure();
		test_unused_register();

		drain();
		repeat (4) @(posedge clk);
		if (pending_codes.size() != 0) begin
			$error("key_code expected %0d actual none", pending_codes[0]);
			errors++;
		end
		if (errors == 0)
			$display("key_press_long_press_scanner: match");
		else
			$display("key_press_long_press_scanner: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
src/kpls_pkg.sv
src/kpls_ifs.sv
src/kpls_lane.sv
src/kpls_merge.sv
src/key_press_long_press_scanner.sv
src/kpls_chk.sv
tb/tb.sv
